[sv/mtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants for the transmit fragmenter
// Field widths, status codes and the structs passed between the sequencer
// and the fragment step unit.
// ----------------------------------------------------------------------------
package mtf_pkg;

    // Field widths
    localparam int PREFIX_W = 6;
    localparam int BODY_W   = 12;
    localparam int MTU_W    = 13;
    localparam int STREAM_W = 13;   // prefix + body
    localparam int POS_W    = 14;   // stream position plus one mtu
    localparam int OFF_W    = 12;
    localparam int BYTES_W  = 13;
    localparam int SEQ_W    = 2;

    localparam logic [MTU_W-1:0] MTU_RESET = 13'd64;

    typedef enum logic
    {
        STATUS_OK      = 1'b0,
        STATUS_INVALID = 1'b1
    } status_t;

    // One fragment descriptor as held in the output register
    typedef struct packed
    {
        status_t              status;
        logic                 start_of_message;
        logic                 end_of_message;
        logic [SEQ_W-1:0]     packet_sequence;
        logic                 carries_prefix;
        logic [OFF_W-1:0]     source_offset;
        logic [BYTES_W-1:0]   body_bytes;
        logic                 last;
    } frag_out_t;

    // Result of one pass through the step unit
    typedef struct packed
    {
        logic                 carries_prefix;
        logic                 final_frag;
        logic [OFF_W-1:0]     source_offset;
        logic [BYTES_W-1:0]   body_bytes;
        logic [POS_W-1:0]     next_start;
    } frag_step_t;

endpackage

[sv/mtf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_if: valid/ready channels of the transmit fragmenter
// Message descriptor input, fragment descriptor output and MTU write port.
// ----------------------------------------------------------------------------

interface mtf_msg_if;
    logic        valid;
    logic        ready;
    logic [5:0]  prefix_length;
    logic [11:0] body_length;

    modport source (output valid, output prefix_length, output body_length, input ready);
    modport sink   (input valid, input prefix_length, input body_length, output ready);
endinterface

interface mtf_frag_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        start_of_message;
    logic        end_of_message;
    logic [1:0]  packet_sequence;
    logic        carries_prefix;
    logic [11:0] source_offset;
    logic [12:0] body_bytes;
    logic        last;

    modport source
    (
        output valid, output status, output start_of_message, output end_of_message,
        output packet_sequence, output carries_prefix, output source_offset,
        output body_bytes, output last, input ready
    );
    modport sink
    (
        input valid, input status, input start_of_message, input end_of_message,
        input packet_sequence, input carries_prefix, input source_offset,
        input body_bytes, input last, output ready
    );
endinterface

interface mtf_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] mtu;

    modport source (output valid, output mtu, input ready);
    modport sink   (input valid, input mtu, output ready);
endinterface

[sv/mtf_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_step_unit: shared fragment step datapath
// From the current stream position, works out one fragment's clipped end,
// body byte count, body offset and prefix flag, and the next start position.
// ----------------------------------------------------------------------------
module mtf_step_unit
    import mtf_pkg::*;
(
    input  logic [POS_W-1:0]    start,
    input  logic [MTU_W-1:0]    mtu,
    input  logic [PREFIX_W-1:0] prefix_length,
    input  logic [STREAM_W-1:0] stream_length,
    output frag_step_t          step
);

    logic [POS_W-1:0] stop_raw;
    logic [POS_W-1:0] stop;
    logic [POS_W-1:0] pre_pos;
    logic [POS_W-1:0] body_start;
    logic [POS_W-1:0] body_stop;
    logic [POS_W-1:0] bytes;
    logic [POS_W-1:0] offset;

    // Fragment end, clipped to the end of the stream
    assign stop_raw = start + POS_W'(mtu);
    assign stop     = (stop_raw >= POS_W'(stream_length)) ? POS_W'(stream_length) : stop_raw;

    // Body window of this fragment
    assign pre_pos    = POS_W'(prefix_length);
    assign body_start = (start > pre_pos) ? start : pre_pos;
    assign body_stop  = (stop > pre_pos) ? stop : pre_pos;
    assign bytes      = body_stop - body_start;
    assign offset     = (bytes != '0) ? (body_start - pre_pos) : '0;

    always_comb
    begin
        step.carries_prefix = (start < pre_pos);
        step.final_frag     = (stop_raw >= POS_W'(stream_length));
        step.source_offset  = offset[OFF_W-1:0];
        step.body_bytes     = bytes[BYTES_W-1:0];
        step.next_start     = stop_raw;
    end

endmodule

[sv/mctp_tx_fragmenter.sv]
`timescale 1ns / 1ps
// The first fragment descriptor passes the check state, then the emit state, into the output register.
// A message gives one fragment per cycle through the shared step unit while the output is
//   not stalled; an empty or oversized message gives a single error result.
// The output register lets the next message be taken while the final descriptor waits.
// Reset (rst_n low, async): sequencer idle, output empty, MTU back to 64.
// ----------------------------------------------------------------------------
// mctp_tx_fragmenter: MCTP transmit fragment descriptor generator
// Takes a message descriptor (prefix and body length) and emits one
// descriptor per MTU-sized fragment, or one error result for an empty or
// oversized message.
// ----------------------------------------------------------------------------
module mctp_tx_fragmenter
    import mtf_pkg::*;
#(
    parameter int MIN_MTU       = 64,
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    mtf_cfg_if.sink    cfg,
    mtf_msg_if.sink    msg,
    mtf_frag_if.source frag
);

    localparam int IDX_W = $clog2(MAX_FRAGMENTS);
    localparam int LIM_W = MTU_W + $clog2(MAX_FRAGMENTS + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t              state_reg,     state_next;
    logic [MTU_W-1:0]    mtu_reg,       mtu_next;
    logic [LIM_W-1:0]    limit_reg,     limit_next;
    logic [PREFIX_W-1:0] pre_reg,       pre_next;
    logic [STREAM_W-1:0] stream_reg,    stream_next;
    logic                body_zero_reg, body_zero_next;
    logic [POS_W-1:0]    start_reg,     start_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic                out_valid_reg, out_valid_next;
    frag_out_t           out_reg,       out_next;

    logic                out_free;
    frag_step_t          step;

    // Shared step unit
    mtf_step_unit u_step
    (
        .start         (start_reg),
        .mtu           (mtu_reg),
        .prefix_length (pre_reg),
        .stream_length (stream_reg),
        .step          (step)
    );

    assign out_free  = !out_valid_reg || frag.ready;
    assign msg.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Sequencer and output register next state
    always_comb
    begin
        state_next     = state_reg;
        mtu_next       = mtu_reg;
        limit_next     = limit_reg;
        pre_next       = pre_reg;
        stream_next    = stream_reg;
        body_zero_next = body_zero_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !frag.ready;
        out_next       = out_reg;

        // MTU write; values below the minimum are dropped
        if (cfg.valid && (cfg.mtu >= MTU_W'(MIN_MTU)))
        begin
            mtu_next   = cfg.mtu;
            limit_next = LIM_W'(cfg.mtu) * LIM_W'(MAX_FRAGMENTS);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    pre_next       = msg.prefix_length;
                    stream_next    = STREAM_W'(msg.prefix_length) + STREAM_W'(msg.body_length);
                    body_zero_next = (msg.body_length == '0);
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // Empty body or more fragments than allowed: single error result
                if (body_zero_reg || (LIM_W'(stream_reg) > limit_reg))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = '0;
                        out_next.status = STATUS_INVALID;
                        out_next.last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    start_next = '0;
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_next.status               = STATUS_OK;
                    out_next.start_of_message     = (idx_reg == '0);
                    out_next.end_of_message       = step.final_frag;
                    out_next.packet_sequence      = SEQ_W'(idx_reg);
                    out_next.carries_prefix       = step.carries_prefix;
                    out_next.source_offset        = step.source_offset;
                    out_next.body_bytes           = step.body_bytes;
                    out_next.last                 = step.final_frag;
                    start_next                    = step.next_start;
                    idx_next                      = idx_reg + IDX_W'(1);
                    if (step.final_frag)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mtu_reg       <= MTU_RESET;
            limit_reg     <= LIM_W'(MTU_RESET) * LIM_W'(MAX_FRAGMENTS);
            pre_reg       <= '0;
            stream_reg    <= '0;
            body_zero_reg <= 1'b0;
            start_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mtu_reg       <= mtu_next;
            limit_reg     <= limit_next;
            pre_reg       <= pre_next;
            stream_reg    <= stream_next;
            body_zero_reg <= body_zero_next;
            start_reg     <= start_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Output port
    assign frag.valid            = out_valid_reg;
    assign frag.status           = out_reg.status;
    assign frag.start_of_message = out_reg.start_of_message;
    assign frag.end_of_message   = out_reg.end_of_message;
    assign frag.packet_sequence  = out_reg.packet_sequence;
    assign frag.carries_prefix   = out_reg.carries_prefix;
    assign frag.source_offset    = out_reg.source_offset;
    assign frag.body_bytes       = out_reg.body_bytes;
    assign frag.last             = out_reg.last;

    // Checks
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frag.valid && (frag.status == STATUS_INVALID)) |-> (frag.last && !frag.start_of_message))
        else $error("error result not marked last");

    a_eom_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frag.valid && frag.end_of_message) |-> (frag.last && (frag.status == STATUS_OK)))
        else $error("end of message without last");

    a_mtu_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mtu_reg >= MTU_W'(MIN_MTU)) || (mtu_reg == MTU_RESET))
        else $error("mtu register below minimum");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready) |=> !msg.ready)
        else $error("message accepted while busy");

    a_emit_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (start_reg < POS_W'(stream_reg)))
        else $error("fragment start past end of stream");

endmodule

[tb/tb_mctp_tx_fragmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mctp_tx_fragmenter: self-checking bench for the MCTP transmit fragmenter
// Sends message descriptors and MTU writes, predicts every fragment
// descriptor from the prefix, body and MTU, and matches each accepted
// fragment field by field, in order. Both sides idle at random.
// ----------------------------------------------------------------------------
import mtf_pkg::*;

// Expected fragment descriptors for the messages accepted so far
class fragment_plan;
    localparam int MAX_FRAGS = 64;
    localparam int MIN_MTU   = 64;
    localparam int SEQ_MOD   = 4;

    frag_out_t          planned_frags[$];
    logic [MTU_W-1:0]   mtu;
    int                 mismatches;

    function new();
        mtu        = MTU_RESET;
        mismatches = 0;
    endfunction

    // MTU register write; values below the minimum are dropped
    function void write_mtu(logic [MTU_W-1:0] value);
        if (value >= MIN_MTU)
            mtu = value;
    endfunction

    function int pending();
        return planned_frags.size();
    endfunction

    // Cut prefix + body into mtu-sized pieces, one descriptor per piece
    function void plan_message(logic [PREFIX_W-1:0] pre, logic [BODY_W-1:0] body);
        int unsigned stream, count, unit, start, stop, bstart, bstop, nbytes, off;
        frag_out_t   f;
        unit   = (mtu == 0) ? 1 : mtu;
        stream = pre + body;
        count  = (stream + unit - 1) / unit;
        // empty body and oversized messages give one error result
        if (body == 0 || count == 0 || count > MAX_FRAGS)
        begin
            f        = '0;
            f.status = STATUS_INVALID;
            f.last   = 1'b1;
            planned_frags.push_back(f);
            return;
        end
        for (int unsigned i = 0; i < count; i++)
        begin
            start = unit * i;
            stop  = start + unit;
            if (stop > stream)
                stop = stream;
            bstart = (start > pre) ? start : pre;
            bstop  = (stop > pre) ? stop : pre;
            nbytes = bstop - bstart;
            off    = (nbytes != 0) ? bstart - pre : 0;
            f                  = '0;
            f.status           = STATUS_OK;
            f.start_of_message = (i == 0);
            f.end_of_message   = (i == count - 1);
            f.packet_sequence  = SEQ_W'(i % SEQ_MOD);
            f.carries_prefix   = (start < pre);
            f.source_offset    = OFF_W'(off);
            f.body_bytes       = BYTES_W'(nbytes);
            f.last             = (i == count - 1);
            planned_frags.push_back(f);
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Match one accepted fragment against the oldest expectation
    function void match_fragment(frag_out_t got);
        frag_out_t want;
        if (planned_frags.size() == 0)
        begin
            $error("fragment descriptor with no message pending");
            mismatches++;
            return;
        end
        want = planned_frags.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("start_of_message", want.start_of_message, got.start_of_message);
        compare_field("end_of_message", want.end_of_message, got.end_of_message);
        compare_field("packet_sequence", want.packet_sequence, got.packet_sequence);
        compare_field("carries_prefix", want.carries_prefix, got.carries_prefix);
        compare_field("source_offset", want.source_offset, got.source_offset);
        compare_field("body_bytes", want.body_bytes, got.body_bytes);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module tb_mctp_tx_fragmenter;

    localparam int MIN_MTU       = 64;
    localparam int MAX_FRAGMENTS = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASES        = 11;
    localparam int MSGS_PER_PHASE = 27;

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   hold_cycles;
    int   quiet_cycles;

    fragment_plan plan;

    mtf_cfg_if  cfg_ch();
    mtf_msg_if  msg_ch();
    mtf_frag_if frag_ch();

    mctp_tx_fragmenter
    #(
        .MIN_MTU       (MIN_MTU),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    )
    u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .msg   (msg_ch),
        .frag  (frag_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 3);
    endfunction

    // Fragment side: backpressure drawn per transaction
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            frag_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            frag_ch.ready = 1'b1;
    end

    // Fragment monitor
    always @(posedge clk)
    begin
        frag_out_t got;
        if (rst_n && frag_ch.valid && frag_ch.ready)
        begin
            got.status           = status_t'(frag_ch.status);
            got.start_of_message = frag_ch.start_of_message;
            got.end_of_message   = frag_ch.end_of_message;
            got.packet_sequence  = frag_ch.packet_sequence;
            got.carries_prefix   = frag_ch.carries_prefix;
            got.source_offset    = frag_ch.source_offset;
            got.body_bytes       = frag_ch.body_bytes;
            got.last             = frag_ch.last;
            plan.match_fragment(got);
            hold_cycles = draw_gap();
        end
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (frag_ch.valid && frag_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Entered and left just after a falling edge
    task automatic send_message(logic [PREFIX_W-1:0] pre, logic [BODY_W-1:0] body);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            msg_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid         = 1'b1;
        msg_ch.prefix_length = pre;
        msg_ch.body_length   = body;
        do @(posedge clk); while (!msg_ch.ready);
        plan.plan_message(pre, body);
        @(negedge clk);
    endtask

    // Hold off input until every planned fragment is out, then let it settle
    task automatic wait_drained();
        msg_ch.valid = 1'b0;
        while (plan.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_mtu_reg(logic [MTU_W-1:0] value);
        wait_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.mtu   = value;
        do @(posedge clk); while (!cfg_ch.ready);
        plan.write_mtu(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [MTU_W-1:0] pick_mtu();
        case ($urandom_range(0, 7))
            0:       return 13'd64;
            1:       return 13'd4096;
            2:       return 13'h1FFF;
            3:       return MTU_W'($urandom_range(0, MIN_MTU - 1));
            4:       return MTU_W'($urandom_range(65, 200));
            default: return MTU_W'($urandom_range(64, 4096));
        endcase
    endfunction

    task automatic send_random_message();
        logic [BODY_W-1:0] body;
        case ($urandom_range(0, 19))
            0:       body = '0;
            1:       body = '1;
            2, 3, 4, 5, 6, 7, 8, 9:
                     body = BODY_W'($urandom_range(1, 256));
            default: body = BODY_W'($urandom_range(1, 4095));
        endcase
        send_message(PREFIX_W'($urandom_range(0, 63)), body);
    endtask

    // Stimulus
    initial
    begin
        plan                 = new();
        rst_n                = 1'b0;
        no_gaps              = 1'b0;
        hold_cycles          = 0;
        quiet_cycles         = 0;
        frag_ch.ready        = 1'b0;
        msg_ch.valid         = 1'b0;
        msg_ch.prefix_length = '0;
        msg_ch.body_length   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.mtu           = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset MTU, field extremes, empty and oversized messages
        send_message(6'd0, 12'd1);
        send_message(6'd63, 12'd1);
        send_message(6'd0, 12'd0);
        send_message(6'd63, 12'd0);
        send_message(6'd0, 12'd64);
        send_message(6'd0, 12'd65);
        send_message(6'd32, 12'd100);
        send_message(6'd63, 12'd4032);
        send_message(6'd0, 12'd4095);
        send_message(6'd63, 12'd4095);
        send_message(6'd1, 12'd4032);

        // MTU writes below the minimum are dropped
        write_mtu_reg(13'd0);
        send_message(6'd10, 12'd200);
        write_mtu_reg(13'd63);
        send_message(6'd63, 12'd4095);

        // Largest MTU values
        write_mtu_reg(13'h1FFF);
        send_message(6'd63, 12'd4095);
        send_message(6'd0, 12'd1);
        send_message(6'd5, 12'd0);
        write_mtu_reg(13'd4096);
        send_message(6'd63, 12'd4095);
        send_message(6'd0, 12'd4095);

        // Just above the minimum, then back to it
        write_mtu_reg(13'd65);
        send_message(6'd63, 12'd4095);
        send_message(6'd2, 12'd63);
        write_mtu_reg(13'd64);
        send_message(6'd1, 12'd63);
        send_message(6'd63, 12'd65);

        // Random phases, each with its own MTU and idling mode
        for (int p = 0; p < PHASES; p++)
        begin
            write_mtu_reg(pick_mtu());
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int m = 0; m < MSGS_PER_PHASE; m++)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
                send_random_message();
            end
        end

        wait_drained();
        if (plan.mismatches == 0 && plan.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
